// File: rtl/mwma_pkg.sv
// ============================================================================
// mwma_pkg
// Shared constants for the multi-window moving average block: default
// widths, window lengths and the layout of the constant-divider chain.
// ============================================================================
package mwma_pkg;

    // Default field widths and long window length
    localparam int PRICE_WIDTH_DEF  = 32;
    localparam int VOLUME_WIDTH_DEF = 40;
    localparam int LONG_WINDOW_DEF  = 60;

    // Fixed window lengths
    localparam int WIN_A = 5;
    localparam int WIN_B = 10;
    localparam int WIN_C = 20;

    // Volume history depth (longest volume window)
    localparam int VOL_DEPTH = WIN_B;

    // Quotient bits resolved by one divider cell
    localparam int STEP_BITS = 4;

    // Divider lane indexes
    localparam int DIV_CLOSE_5   = 0;
    localparam int DIV_CLOSE_10  = 1;
    localparam int DIV_CLOSE_20  = 2;
    localparam int DIV_CLOSE_L   = 3;
    localparam int DIV_VOLUME_5  = 4;
    localparam int DIV_VOLUME_10 = 5;
    localparam int NUM_DIV       = 6;

endpackage

// File: rtl/mwma_if.sv
// ============================================================================
// mwma_if
// Valid/ready channels of the moving average block: one bar in, one set of
// averages out.
// ============================================================================

// Bar channel
interface mwma_in_if #(
    parameter int PRICE_WIDTH  = mwma_pkg::PRICE_WIDTH_DEF,
    parameter int VOLUME_WIDTH = mwma_pkg::VOLUME_WIDTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic                    restart;
    logic [PRICE_WIDTH-1:0]  close_price;
    logic [VOLUME_WIDTH-1:0] volume;

    modport source (output valid, output restart, output close_price, output volume,
                    input ready);
    modport sink   (input valid, input restart, input close_price, input volume,
                    output ready);
endinterface

// Average channel
interface mwma_out_if #(
    parameter int PRICE_WIDTH  = mwma_pkg::PRICE_WIDTH_DEF,
    parameter int VOLUME_WIDTH = mwma_pkg::VOLUME_WIDTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [PRICE_WIDTH-1:0]  avg_close_5;
    logic [PRICE_WIDTH-1:0]  avg_close_10;
    logic [PRICE_WIDTH-1:0]  avg_close_20;
    logic [PRICE_WIDTH-1:0]  avg_close_60;
    logic [VOLUME_WIDTH-1:0] avg_volume_5;
    logic [VOLUME_WIDTH-1:0] avg_volume_10;

    modport source (output valid, output avg_close_5, output avg_close_10,
                    output avg_close_20, output avg_close_60,
                    output avg_volume_5, output avg_volume_10, input ready);
    modport sink   (input valid, input avg_close_5, input avg_close_10,
                    input avg_close_20, input avg_close_60,
                    input avg_volume_5, input avg_volume_10, output ready);
endinterface

// File: rtl/mwma_div_cell.sv
// ============================================================================
// mwma_div_cell
// One cell of a constant-divisor restoring divider chain. Each cell shifts
// STEP_BITS dividend bits into the partial remainder, produces the matching
// quotient bits and registers the result for its right-hand neighbor.
// ============================================================================
module mwma_div_cell #(
    parameter int WIDTH     = 44,
    parameter int DIVISOR   = mwma_pkg::WIN_A,
    parameter int STEP_BITS = mwma_pkg::STEP_BITS,
    parameter int REM_W     = $clog2(DIVISOR)
) (
    input  logic             clk,
    input  logic             shift,
    input  logic [REM_W-1:0] rem_in,
    input  logic [WIDTH-1:0] work_in,
    output logic [REM_W-1:0] rem_out,
    output logic [WIDTH-1:0] work_out
);
    import mwma_pkg::*;

    logic [REM_W-1:0] rem_next;
    logic [WIDTH-1:0] work_next;
    logic [REM_W-1:0] rem_reg;
    logic [WIDTH-1:0] work_reg;

    // STEP_BITS restoring steps; work holds dividend bits above, quotient below
    always_comb
    begin
        logic [REM_W:0] trial;
        rem_next  = rem_in;
        work_next = work_in;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial     = {rem_next, work_next[WIDTH-1]};
            work_next = {work_next[WIDTH-2:0], 1'b0};
            if (trial >= (REM_W+1)'(DIVISOR))
            begin
                rem_next     = REM_W'(trial - (REM_W+1)'(DIVISOR));
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = REM_W'(trial);
            end
        end
    end

    // Stage register (payload only)
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign rem_out  = rem_reg;
    assign work_out = work_reg;

endmodule

// File: rtl/mwma_window_sums.sv
// ============================================================================
// mwma_window_sums
// Price and volume history shift lines with running window sums. On each
// accepted bar the oldest bar of every full window is subtracted, the new bar is
// added and the history shifts one place.
// ============================================================================
module mwma_window_sums #(
    parameter int PRICE_WIDTH  = mwma_pkg::PRICE_WIDTH_DEF,
    parameter int VOLUME_WIDTH = mwma_pkg::VOLUME_WIDTH_DEF,
    parameter int LONG_WINDOW  = mwma_pkg::LONG_WINDOW_DEF,
    parameter int CNT_W        = $clog2(LONG_WINDOW + 1),
    parameter int SC5_W        = PRICE_WIDTH + $clog2(mwma_pkg::WIN_A),
    parameter int SC10_W       = PRICE_WIDTH + $clog2(mwma_pkg::WIN_B),
    parameter int SC20_W       = PRICE_WIDTH + $clog2(mwma_pkg::WIN_C),
    parameter int SCL_W        = PRICE_WIDTH + $clog2(LONG_WINDOW),
    parameter int SV5_W        = VOLUME_WIDTH + $clog2(mwma_pkg::WIN_A),
    parameter int SV10_W       = VOLUME_WIDTH + $clog2(mwma_pkg::WIN_B)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic                    restart,
    input  logic [PRICE_WIDTH-1:0]  close_price,
    input  logic [VOLUME_WIDTH-1:0] volume,
    output logic [CNT_W-1:0]        bars_seen,
    output logic [SC5_W-1:0]        sum_close_5,
    output logic [SC10_W-1:0]       sum_close_10,
    output logic [SC20_W-1:0]       sum_close_20,
    output logic [SCL_W-1:0]        sum_close_l,
    output logic [SV5_W-1:0]        sum_volume_5,
    output logic [SV10_W-1:0]       sum_volume_10
);
    import mwma_pkg::*;

    logic [PRICE_WIDTH-1:0]  price_reg [LONG_WINDOW];
    logic [VOLUME_WIDTH-1:0] vol_reg   [VOL_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next, n_cur;
    logic [SC5_W-1:0]  sum_c5_reg, sum_c5_next;
    logic [SC10_W-1:0] sum_c10_reg, sum_c10_next;
    logic [SC20_W-1:0] sum_c20_reg, sum_c20_next;
    logic [SCL_W-1:0]  sum_cl_reg, sum_cl_next;
    logic [SV5_W-1:0]  sum_v5_reg, sum_v5_next;
    logic [SV10_W-1:0] sum_v10_reg, sum_v10_next;

    // Restart drops the series before the bar is taken in
    assign n_cur = restart ? '0 : count_reg;

    // Window sums: add new bar, drop the one leaving each full window
    always_comb
    begin
        logic [SC5_W-1:0]  drop_c5;
        logic [SC10_W-1:0] drop_c10;
        logic [SC20_W-1:0] drop_c20;
        logic [SCL_W-1:0]  drop_cl;
        logic [SV5_W-1:0]  drop_v5;
        logic [SV10_W-1:0] drop_v10;

        drop_c5  = (n_cur >= CNT_W'(WIN_A)) ? SC5_W'(price_reg[WIN_A-1]) : '0;
        drop_c10 = (n_cur >= CNT_W'(WIN_B)) ? SC10_W'(price_reg[WIN_B-1]) : '0;
        drop_c20 = (n_cur >= CNT_W'(WIN_C)) ? SC20_W'(price_reg[WIN_C-1]) : '0;
        drop_cl  = (n_cur >= CNT_W'(LONG_WINDOW)) ?
                   SCL_W'(price_reg[LONG_WINDOW-1]) : '0;
        drop_v5  = (n_cur >= CNT_W'(WIN_A)) ? SV5_W'(vol_reg[WIN_A-1]) : '0;
        drop_v10 = (n_cur >= CNT_W'(WIN_B)) ? SV10_W'(vol_reg[VOL_DEPTH-1]) : '0;

        sum_c5_next  = (restart ? '0 : sum_c5_reg) + SC5_W'(close_price) - drop_c5;
        sum_c10_next = (restart ? '0 : sum_c10_reg) + SC10_W'(close_price) - drop_c10;
        sum_c20_next = (restart ? '0 : sum_c20_reg) + SC20_W'(close_price) - drop_c20;
        sum_cl_next  = (restart ? '0 : sum_cl_reg) + SCL_W'(close_price) - drop_cl;
        sum_v5_next  = (restart ? '0 : sum_v5_reg) + SV5_W'(volume) - drop_v5;
        sum_v10_next = (restart ? '0 : sum_v10_reg) + SV10_W'(volume) - drop_v10;

        // Bar count saturates at the long window
        count_next = (n_cur < CNT_W'(LONG_WINDOW)) ? n_cur + CNT_W'(1) : n_cur;
    end

    // Sums and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sum_c5_reg  <= '0;
            sum_c10_reg <= '0;
            sum_c20_reg <= '0;
            sum_cl_reg  <= '0;
            sum_v5_reg  <= '0;
            sum_v10_reg <= '0;
        end
        else if (load)
        begin
            count_reg   <= count_next;
            sum_c5_reg  <= sum_c5_next;
            sum_c10_reg <= sum_c10_next;
            sum_c20_reg <= sum_c20_next;
            sum_cl_reg  <= sum_cl_next;
            sum_v5_reg  <= sum_v5_next;
            sum_v10_reg <= sum_v10_next;
        end
    end

    // History shift lines: cell 0 holds the newest bar
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            price_reg[0] <= close_price;
            for (int i = 1; i < LONG_WINDOW; i++)
            begin
                price_reg[i] <= price_reg[i-1];
            end
            vol_reg[0] <= volume;
            for (int i = 1; i < VOL_DEPTH; i++)
            begin
                vol_reg[i] <= vol_reg[i-1];
            end
        end
    end

    assign bars_seen     = count_reg;
    assign sum_close_5   = sum_c5_reg;
    assign sum_close_10  = sum_c10_reg;
    assign sum_close_20  = sum_c20_reg;
    assign sum_close_l   = sum_cl_reg;
    assign sum_volume_5  = sum_v5_reg;
    assign sum_volume_10 = sum_v10_reg;

endmodule

// File: rtl/multi_window_moving_average.sv
// ============================================================================
// multi_window_moving_average
// Simple moving averages of close price (5, 10, 20, long window) and of
// volume (5, 10) over a stream of bars.
// ============================================================================
// Usage:
//   bar : valid/ready sink. One transfer per bar: restart, close_price, volume.
//         restart = 1 begins a new series with this bar.
//   avg : valid/ready source. One transfer per bar with six averages; an
//         average reads 0 until its window holds enough bars of the series.
// Pipeline: the window sums register, then STAGES divider cells, where STAGES
//   is ceil(max(PRICE_WIDTH + clog2(LONG_WINDOW), VOLUME_WIDTH + 3) / 4);
//   11 cells with the default widths.
// Throughput: one bar per cycle while avg is ready. The window sums are
//   registered; the averages come out of a chain of divider cells that resolve 4
//   quotient bits each and move one place per cycle when not held.
// Reset: clears the bar count, window sums and all pipeline valid flags; the
//   history needs no clearing since unfilled windows are never read.
// Stall: when avg is not ready, the chain compacts bubbles and then holds;
//   bar stays ready while any stage ahead is empty.
// ============================================================================
module multi_window_moving_average #(
    parameter int PRICE_WIDTH  = mwma_pkg::PRICE_WIDTH_DEF,
    parameter int VOLUME_WIDTH = mwma_pkg::VOLUME_WIDTH_DEF,
    parameter int LONG_WINDOW  = mwma_pkg::LONG_WINDOW_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mwma_in_if.sink   bar,
    mwma_out_if.source avg
);
    import mwma_pkg::*;

    localparam int CNT_W   = $clog2(LONG_WINDOW + 1);
    localparam int SC5_W   = PRICE_WIDTH + $clog2(WIN_A);
    localparam int SC10_W  = PRICE_WIDTH + $clog2(WIN_B);
    localparam int SC20_W  = PRICE_WIDTH + $clog2(WIN_C);
    localparam int SCL_W   = PRICE_WIDTH + $clog2(LONG_WINDOW);
    localparam int SV5_W   = VOLUME_WIDTH + $clog2(WIN_A);
    localparam int SV10_W  = VOLUME_WIDTH + $clog2(WIN_B);
    // Widest dividend after pre-shifting the 10 and 20 windows to a /5
    localparam int DIV_W   = (SCL_W > SV5_W) ? SCL_W : SV5_W;
    localparam int STAGES  = (DIV_W + STEP_BITS - 1) / STEP_BITS;
    localparam int EXT_W   = STAGES * STEP_BITS;

    logic              accept;
    logic [CNT_W-1:0]  bars_seen;
    logic [SC5_W-1:0]  sum_close_5;
    logic [SC10_W-1:0] sum_close_10;
    logic [SC20_W-1:0] sum_close_20;
    logic [SCL_W-1:0]  sum_close_l;
    logic [SV5_W-1:0]  sum_volume_5;
    logic [SV10_W-1:0] sum_volume_10;

    logic              vld_s_reg;
    logic [STAGES-1:0] vld_c_reg, vld_c_next, en_c;
    logic [EXT_W-1:0]  dividend [NUM_DIV];
    logic [EXT_W-1:0]  quot     [NUM_DIV];

    // Running sums and history
    mwma_window_sums #(
        .PRICE_WIDTH  (PRICE_WIDTH),
        .VOLUME_WIDTH (VOLUME_WIDTH),
        .LONG_WINDOW  (LONG_WINDOW)
    ) u_sums (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .restart       (bar.restart),
        .close_price   (bar.close_price),
        .volume        (bar.volume),
        .bars_seen     (bars_seen),
        .sum_close_5   (sum_close_5),
        .sum_close_10  (sum_close_10),
        .sum_close_20  (sum_close_20),
        .sum_close_l   (sum_close_l),
        .sum_volume_5  (sum_volume_5),
        .sum_volume_10 (sum_volume_10)
    );

    // Stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en_c[STAGES-1] = !vld_c_reg[STAGES-1] || avg.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en_c[k] = !vld_c_reg[k] || en_c[k+1];
        end
    end

    assign bar.ready = !vld_s_reg || en_c[0];
    assign accept    = bar.valid && bar.ready;

    // Valid flags along the divider chain
    always_comb
    begin
        logic [STAGES-1:0] vld_in;
        vld_in     = {vld_c_reg[STAGES-2:0], vld_s_reg};
        vld_c_next = vld_c_reg;
        for (int k = 0; k < STAGES; k++)
        begin
            if (en_c[k])
            begin
                vld_c_next[k] = vld_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s_reg <= 1'b0;
            vld_c_reg <= '0;
        end
        else
        begin
            vld_s_reg <= accept || (vld_s_reg && !en_c[0]);
            vld_c_reg <= vld_c_next;
        end
    end

    // Dividends; a window that is not full divides zero
    assign dividend[DIV_CLOSE_5]   = (bars_seen >= CNT_W'(WIN_A)) ?
                                     EXT_W'(sum_close_5) : '0;
    assign dividend[DIV_CLOSE_10]  = (bars_seen >= CNT_W'(WIN_B)) ?
                                     EXT_W'(sum_close_10 >> 1) : '0;
    assign dividend[DIV_CLOSE_20]  = (bars_seen >= CNT_W'(WIN_C)) ?
                                     EXT_W'(sum_close_20 >> 2) : '0;
    assign dividend[DIV_CLOSE_L]   = (bars_seen == CNT_W'(LONG_WINDOW)) ?
                                     EXT_W'(sum_close_l) : '0;
    assign dividend[DIV_VOLUME_5]  = (bars_seen >= CNT_W'(WIN_A)) ?
                                     EXT_W'(sum_volume_5) : '0;
    assign dividend[DIV_VOLUME_10] = (bars_seen >= CNT_W'(WIN_B)) ?
                                     EXT_W'(sum_volume_10 >> 1) : '0;

    // Divider chains, one per average; the 10 and 20 windows divide by 5
    // after a shift
    for (genvar d = 0; d < NUM_DIV; d++)
    begin : g_div
        localparam int DIVISOR = (d == DIV_CLOSE_L) ? LONG_WINDOW : WIN_A;
        localparam int REM_W   = $clog2(DIVISOR);

        logic [REM_W-1:0] rem_q  [STAGES+1];
        logic [EXT_W-1:0] work_q [STAGES+1];

        assign rem_q[0]  = '0;
        assign work_q[0] = dividend[d];

        for (genvar k = 0; k < STAGES; k++)
        begin : g_cell
            mwma_div_cell #(
                .WIDTH     (EXT_W),
                .DIVISOR   (DIVISOR),
                .STEP_BITS (STEP_BITS),
                .REM_W     (REM_W)
            ) u_cell (
                .clk      (clk),
                .shift    (en_c[k]),
                .rem_in   (rem_q[k]),
                .work_in  (work_q[k]),
                .rem_out  (rem_q[k+1]),
                .work_out (work_q[k+1])
            );
        end

        assign quot[d] = work_q[STAGES];
    end

    // Output from the last cell
    assign avg.valid         = vld_c_reg[STAGES-1];
    assign avg.avg_close_5   = quot[DIV_CLOSE_5][PRICE_WIDTH-1:0];
    assign avg.avg_close_10  = quot[DIV_CLOSE_10][PRICE_WIDTH-1:0];
    assign avg.avg_close_20  = quot[DIV_CLOSE_20][PRICE_WIDTH-1:0];
    assign avg.avg_close_60  = quot[DIV_CLOSE_L][PRICE_WIDTH-1:0];
    assign avg.avg_volume_5  = quot[DIV_VOLUME_5][VOLUME_WIDTH-1:0];
    assign avg.avg_volume_10 = quot[DIV_VOLUME_10][VOLUME_WIDTH-1:0];

    // Checks
    a_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        avg.ready |-> bar.ready)
        else $error("bar not ready although avg is ready");

    a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && bar.restart) |=> (bars_seen == CNT_W'(1)))
        else $error("restart did not start a new series");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bars_seen <= CNT_W'(LONG_WINDOW))
        else $error("bar count above long window");

    a_sums_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_s_reg && !en_c[0]) |=> (vld_s_reg && $stable(sum_close_l)))
        else $error("window sums lost before entering divider chain");

endmodule
